// File: hw/rtl/run_hour_meter_with_hold_reset_macros.svh
// assertion macros for the run-hour meter checker
// no dependencies; included by the files that assert
`ifndef RUN_HOUR_METER_WITH_HOLD_RESET_MACROS_SVH
`define RUN_HOUR_METER_WITH_HOLD_RESET_MACROS_SVH

// same-cycle implication, held off during reset
`define RHM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rhm_pkg.sv
// shared types, codes and constants of the run-hour meter
// no dependencies; used by every module of the block
`default_nettype none

package rhm_pkg;

  // default width of the tick and hour counters
  localparam int COUNT_WIDTH_DEF = 16;

  // field widths
  localparam int TPH_W   = 16;
  localparam int THR_W   = 6;
  localparam int HOURS_W = 16;
  localparam int FRAC_W  = 10;
  localparam int DIGIT_W = 3;
  localparam int HOLD_W  = 7;
  localparam int IDX_W   = 4;
  localparam int NUM_W   = TPH_W + FRAC_W;

  // register indexes on the config port
  localparam logic [1:0] REG_TPH  = 2'd0;
  localparam logic [1:0] REG_CTHR = 2'd1;
  localparam logic [1:0] REG_RTHR = 2'd2;

  // register reset values
  localparam logic [TPH_W-1:0] TPH_RST  = 16'd7200;
  localparam logic [THR_W-1:0] CTHR_RST = 6'd5;
  localparam logic [THR_W-1:0] RTHR_RST = 6'd16;

  // result kinds
  localparam logic [1:0] ACT_TOTALS    = 2'd0;
  localparam logic [1:0] ACT_COUNTDOWN = 2'd1;
  localparam logic [1:0] ACT_BLANK     = 2'd2;

  // saturation points
  localparam logic [HOLD_W-1:0] HOLD_MAX   = 7'd127;
  localparam logic [IDX_W-1:0]  DIGIT_LAST = 4'd11;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 10'd999;

  // request and response between the control and the divider
  typedef struct packed {
    logic             start;
    logic [TPH_W-1:0] dividend;
    logic [TPH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quotient;
  } div_rsp_t;

  // countdown digit sequence 5,5,4,4,...,0,0
  function automatic logic [DIGIT_W-1:0] digit_at(input logic [IDX_W-1:0] idx);
    logic [DIGIT_W-1:0] d;
    case (idx)
      4'd0, 4'd1: d = 3'd5;
      4'd2, 4'd3: d = 3'd4;
      4'd4, 4'd5: d = 3'd3;
      4'd6, 4'd7: d = 3'd2;
      4'd8, 4'd9: d = 3'd1;
      default:    d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rhm_frac_div.sv
// bit-serial unit for floor(wet * 1000 / ticks_per_hour), quotient below 1000 while wet is below ticks_per_hour
// depends on rhm_pkg for widths and the request/response structs
`default_nettype none

module rhm_frac_div (
  input  wire                 clk,
  input  wire                 rst,
  input  rhm_pkg::div_req_t   req,
  output rhm_pkg::div_rsp_t   rsp
);

  localparam int DW    = rhm_pkg::TPH_W;
  localparam int FW    = rhm_pkg::FRAC_W;
  localparam int NW    = rhm_pkg::NUM_W;
  localparam int CNT_W = $clog2(NW + 1);
  localparam int PW    = DW + 5;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_LOAD = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;
  localparam logic [1:0] D_DONE = 2'd3;

  logic [1:0]       state;
  logic [DW-1:0]    dvd;
  logic [DW-1:0]    dvs;
  logic [PW-1:0]    p24;
  logic [NW-1:0]    num;
  logic [DW-1:0]    rem;
  logic [FW-1:0]    quo;
  logic [CNT_W-1:0] cnt;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {rem, num[NW-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            dvd   <= req.dividend;
            dvs   <= req.divisor;
            // wet * 24, to be taken from wet * 1024
            p24   <= {1'b0, req.dividend, 4'b0} + {2'b0, req.dividend, 3'b0};
            state <= D_LOAD;
          end
        end
        D_LOAD: begin
          num   <= {dvd, {FW{1'b0}}} - {{(NW - PW){1'b0}}, p24};
          rem   <= '0;
          cnt   <= CNT_W'(NW);
          state <= D_RUN;
        end
        D_RUN: begin
          rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
          num <= {num[NW-2:0], 1'b0};
          quo <= {quo[FW-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= D_DONE;
          end
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = (state == D_DONE);
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// File: hw/rtl/run_hour_meter_with_hold_reset.sv
// run-hour meter with press-and-hold reset, top level
// depends on rhm_pkg and rhm_frac_div
`default_nettype none

// One input beat is one half-second tick. Its results (countdown digit, blank,
// totals, in that order, last one flagged with tlast) leave through a one-beat
// output register, one per cycle when the sink is ready and, for totals, once
// the quotient is back. The next tick is taken only after every result of the
// last one is loaded. A tick with a press waits on the thousandths, which
// come from a bit-serial divider that takes a start step, a multiply step and
// 26 one-bit restoring steps, one for each bit of wet_ticks * 1000.
module run_hour_meter_with_hold_reset #(
  parameter int COUNT_WIDTH = rhm_pkg::COUNT_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // config write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [15:0] cfg_wdata,
  // tick input
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [0] water_present, [1] button_held, [2] button_pressed
  // result output
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] hours_total, [25:16] thousandths,
                                      // [28:26] countdown_digit
  output logic [1:0]  m_axis_tuser,   // [1:0] action
  output logic        m_axis_tlast
);

  localparam int TW = rhm_pkg::TPH_W;
  localparam int CW = COUNT_WIDTH;
  localparam int HW = rhm_pkg::HOLD_W;
  localparam int IW = rhm_pkg::IDX_W;
  localparam int FW = rhm_pkg::FRAC_W;
  localparam int DW = rhm_pkg::DIGIT_W;
  localparam int OW = rhm_pkg::HOURS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  // config registers
  logic [TW-1:0]                tph;
  logic [rhm_pkg::THR_W-1:0]    cthr;
  logic [rhm_pkg::THR_W-1:0]    rthr;

  // meter state
  logic [CW-1:0] wet;
  logic [CW-1:0] hour;
  logic          holding;
  logic [HW-1:0] hold_ticks;
  logic [IW-1:0] cidx;

  // sequencing
  logic          state;
  logic          pend_cd;
  logic          pend_blank;
  logic          pend_tot;
  logic          frac_ready;
  logic [FW-1:0] frac_q;
  logic [DW-1:0] cd_digit;
  logic          div_go;

  // output register
  logic [1:0]    o_action;
  logic [OW-1:0] o_hours;
  logic [FW-1:0] o_frac;
  logic [DW-1:0] o_digit;

  rhm_pkg::div_req_t div_req;
  rhm_pkg::div_rsp_t div_rsp;

  // input decode
  logic in_fire;
  logic water;
  logic held;
  logic pressed;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign water         = s_axis_tdata[0];
  assign held          = s_axis_tdata[1];
  assign pressed       = s_axis_tdata[2];

  // widened copies for compares against the 16-bit register
  logic [CW+TW-1:0] wet_ext;
  logic [CW+TW-1:0] hour_ext;
  logic [CW+TW-1:0] tph_ext;
  logic [CW-1:0]    wet_inc;
  logic [CW+TW-1:0] wet_inc_ext;

  assign wet_ext     = {{TW{1'b0}}, wet};
  assign hour_ext    = {{TW{1'b0}}, hour};
  assign tph_ext     = {{CW{1'b0}}, tph};
  assign wet_inc     = wet + 1'b1;
  assign wet_inc_ext = {{TW{1'b0}}, wet_inc};

  // water count and hour roll
  logic          roll;
  logic [CW-1:0] wet_upd;
  logic [CW-1:0] hour_upd;

  assign roll     = water && (wet_inc_ext >= tph_ext);
  assign wet_upd  = !water ? wet : (roll ? '0 : wet_inc);
  assign hour_upd = roll ? hour + 1'b1 : hour;

  // hold tracking
  logic          hold_act;
  logic [HW-1:0] ht_inc;
  logic          show_cd;
  logic          do_clear;
  logic          show_blank;
  logic [IW-1:0] cidx_inc;

  assign hold_act   = holding && held;
  assign ht_inc     = (hold_ticks != rhm_pkg::HOLD_MAX) ? hold_ticks + 1'b1 : hold_ticks;
  assign show_cd    = hold_act && (ht_inc > {1'b0, cthr});
  assign do_clear   = hold_act && (ht_inc > {1'b0, rthr});
  assign show_blank = holding && (!held || do_clear);
  assign cidx_inc   = (cidx < rhm_pkg::DIGIT_LAST) ? cidx + 1'b1 : cidx;

  // thousandths selection for the totals beat
  logic          wet_sat;
  logic [FW-1:0] frac_sel;

  assign wet_sat  = (wet_ext >= tph_ext);
  assign frac_sel = (tph == '0) ? '0 : (wet_sat ? rhm_pkg::FRAC_MAX : frac_q);

  // divider
  assign div_req.start    = div_go;
  assign div_req.dividend = wet_ext[TW-1:0];
  assign div_req.divisor  = tph;

  rhm_frac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic slot_free;
  logic any_pend;

  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign any_pend  = pend_cd || pend_blank || pend_tot;

  // config, state update and result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      tph           <= rhm_pkg::TPH_RST;
      cthr          <= rhm_pkg::CTHR_RST;
      rthr          <= rhm_pkg::RTHR_RST;
      wet           <= '0;
      hour          <= '0;
      holding       <= 1'b0;
      hold_ticks    <= '0;
      cidx          <= '0;
      state         <= S_IDLE;
      pend_cd       <= 1'b0;
      pend_blank    <= 1'b0;
      pend_tot      <= 1'b0;
      frac_ready    <= 1'b0;
      div_go        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // config writes
      if (cfg_we) begin
        unique case (cfg_addr)
          rhm_pkg::REG_TPH:  tph  <= cfg_wdata;
          rhm_pkg::REG_CTHR: cthr <= cfg_wdata[rhm_pkg::THR_W-1:0];
          rhm_pkg::REG_RTHR: rthr <= cfg_wdata[rhm_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      div_go <= 1'b0;

      // tick accepted: update counts, queue its results
      if (in_fire) begin
        wet  <= do_clear ? '0 : wet_upd;
        hour <= do_clear ? '0 : hour_upd;
        if (pressed) begin
          holding <= 1'b1;
        end else if (show_blank) begin
          holding <= 1'b0;
        end
        if (show_blank) begin
          hold_ticks <= '0;
          cidx       <= '0;
        end else if (hold_act) begin
          hold_ticks <= ht_inc;
          if (show_cd) begin
            cidx <= cidx_inc;
          end
        end
        pend_cd    <= show_cd;
        cd_digit   <= rhm_pkg::digit_at(cidx);
        pend_blank <= show_blank;
        pend_tot   <= pressed;
        frac_ready <= 1'b0;
        div_go     <= pressed;
        state      <= S_EMIT;
      end

      // quotient back from the divider
      if (div_rsp.done) begin
        frac_q     <= div_rsp.quotient;
        frac_ready <= 1'b1;
      end

      // output beat taken
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // load the next result beat in order
      if (state == S_EMIT) begin
        if (!any_pend) begin
          state <= S_IDLE;
        end else if (slot_free) begin
          if (pend_cd) begin
            o_action      <= rhm_pkg::ACT_COUNTDOWN;
            o_hours       <= '0;
            o_frac        <= '0;
            o_digit       <= cd_digit;
            m_axis_tlast  <= !pend_blank && !pend_tot;
            m_axis_tvalid <= 1'b1;
            pend_cd       <= 1'b0;
          end else if (pend_blank) begin
            o_action      <= rhm_pkg::ACT_BLANK;
            o_hours       <= '0;
            o_frac        <= '0;
            o_digit       <= '0;
            m_axis_tlast  <= !pend_tot;
            m_axis_tvalid <= 1'b1;
            pend_blank    <= 1'b0;
          end else if (frac_ready) begin
            o_action      <= rhm_pkg::ACT_TOTALS;
            o_hours       <= hour_ext[OW-1:0];
            o_frac        <= frac_sel;
            o_digit       <= '0;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            pend_tot      <= 1'b0;
          end
        end
      end
    end
  end

  assign m_axis_tdata = {3'b000, o_digit, o_frac, o_hours};
  assign m_axis_tuser = o_action;

endmodule

`default_nettype wire

// File: hw/rtl/rhm_checker.sv
// port-level checks on the result stream of the run-hour meter
// depends on rhm_pkg and run_hour_meter_with_hold_reset_macros.svh; bound to the top level
`default_nettype none

`include "run_hour_meter_with_hold_reset_macros.svh"

module rhm_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // beat decode for the checks
  logic        is_tot;
  logic        ok_plain;
  logic        ok_totals;
  logic        ok_digit;
  logic        stall;
  logic [34:0] beat;

  assign is_tot    = (m_axis_tuser == rhm_pkg::ACT_TOTALS);
  // countdown and blank beats carry no totals
  assign ok_plain  = is_tot || (m_axis_tdata[25:0] == 26'd0);
  // totals beats carry a thousandths value below one hour, no digit, and tlast
  assign ok_totals = !is_tot || ((m_axis_tdata[25:16] <= rhm_pkg::FRAC_MAX)
                                 && (m_axis_tdata[28:26] == 3'd0) && m_axis_tlast);
  // countdown digit never above five, and other beats carry no digit
  assign ok_digit  = (m_axis_tdata[28:26] <= 3'd5)
                     && (m_axis_tuser == rhm_pkg::ACT_COUNTDOWN || m_axis_tdata[28:26] == 3'd0);
  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign beat      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `RHM_ASSERT_NOW(a_no_totals, clk, rst, m_axis_tvalid, ok_plain, "totals on a plain beat")

  `RHM_ASSERT_NOW(a_totals_range, clk, rst, m_axis_tvalid, ok_totals, "bad totals beat")

  `RHM_ASSERT_NOW(a_digit_range, clk, rst, m_axis_tvalid, ok_digit, "digit out of range")

  // a stalled beat holds
  `RHM_ASSERT_NEXT(a_stall_hold, clk, rst, stall, m_axis_tvalid && $stable(beat), "stall not held")

endmodule

bind run_hour_meter_with_hold_reset rhm_checker u_rhm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
